FILE: rtl/ktb_pkg.sv
// ----------------------------------------------------------------------------
// ktb_pkg
// shared types, constants and state codes of the kendall tau-b counter
// ----------------------------------------------------------------------------
package ktb_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int CNT_W   = 19;
    localparam int SCORE_W = 20;
    localparam int TAU_W   = 32;

    // iteration counts of the tau unit
    localparam int DIVA_STEPS = 31;
    localparam int DIVB_STEPS = 60;
    localparam int SQRT_STEPS = 30;
    localparam int SQRT_TOP   = 58;
    localparam int Q30_SHIFT  = 30;

    typedef struct packed {
        logic signed [31:0] x_key;
        logic signed [31:0] y_key;
        logic               last_item;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0]          pair_total;
        logic [CNT_W-1:0]          ties_first;
        logic [CNT_W-1:0]          ties_second;
        logic [CNT_W-1:0]          ties_joint;
        logic [CNT_W-1:0]          discordant_count;
        logic [CNT_W-1:0]          concordant_count;
        logic signed [SCORE_W-1:0] score;
        logic signed [TAU_W-1:0]   tau_a;
        logic signed [TAU_W-1:0]   tau_b;
        logic                      undefined_flag;
        logic                      overflow_flag;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS,
        ST_RUN,
        ST_FETCH,
        ST_MERGE,
        ST_SCAN,
        ST_CALC,
        ST_FIN,
        ST_TAU,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        T_IDLE,
        T_MULD,
        T_MULS,
        T_DIVA,
        T_BCHK,
        T_DIVB,
        T_SQRT,
        T_DONE
    } t_tau_state;

endpackage

FILE: rtl/ktb_tau.sv
// ----------------------------------------------------------------------------
// ktb_tau
// iterative tau unit: one shared subtract/compare for the tau-a division,
// the scaled tau-b division and the integer square root
// ----------------------------------------------------------------------------
module ktb_tau #(
    parameter int PW = 22
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [PW-1:0]               i_npair,
    input  logic [PW-1:0]               i_m1,
    input  logic [PW-1:0]               i_m2,
    input  logic [PW-1:0]               i_mag,
    input  logic                        i_neg,
    output logic                        o_done,
    output logic [ktb_pkg::TAU_W-1:0]   o_tau_a,
    output logic [ktb_pkg::TAU_W-1:0]   o_tau_b
);
    import ktb_pkg::*;

    localparam int UW = (2 * PW + 2 > 62) ? 2 * PW + 2 : 62;

    t_tau_state r_state, n_state;
    logic [2*PW-1:0] r_d, n_d;
    logic [2*PW-1:0] r_sq, n_sq;
    logic [UW-1:0]   r_rem, n_rem;
    logic [UW-1:0]   r_q, n_q;
    logic [UW-1:0]   r_one, n_one;
    logic [30:0]     r_ta, n_ta;
    logic [30:0]     r_tb, n_tb;
    logic [6:0]      r_cnt, n_cnt;

    logic [UW-1:0]   opa, opb;
    logic [UW:0]     diff;
    logic            ge;

    // shared subtract / compare
    assign diff = {1'b0, opa} - {1'b0, opb};
    assign ge   = ~diff[UW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_d   <= n_d;
        r_sq  <= n_sq;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_one <= n_one;
        r_ta  <= n_ta;
        r_tb  <= n_tb;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_sq    = r_sq;
        n_rem   = r_rem;
        n_q     = r_q;
        n_one   = r_one;
        n_ta    = r_ta;
        n_tb    = r_tb;
        n_cnt   = r_cnt;
        opa     = r_rem;
        opb     = UW'(i_npair);
        o_done  = 1'b0;
        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    n_state = T_MULD;
                end
            end
            T_MULD: begin
                n_d     = (i_npair - i_m1) * (i_npair - i_m2);
                n_state = T_MULS;
            end
            T_MULS: begin
                n_sq    = i_mag * i_mag;
                n_rem   = UW'(i_mag);
                n_ta    = '0;
                n_cnt   = '0;
                n_state = T_DIVA;
            end
            T_DIVA: begin
                // mag * 2^30 / npair, one quotient bit a cycle
                opa   = r_rem;
                opb   = UW'(i_npair);
                n_rem = (ge ? diff[UW-1:0] : r_rem) << 1;
                n_ta  = {r_ta[29:0], ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(DIVA_STEPS - 1)) begin
                    n_state = T_BCHK;
                end
            end
            T_BCHK: begin
                opa = UW'(r_sq);
                opb = UW'(r_d);
                if (ge) begin
                    // quotient reaches one: tau-b saturates
                    n_tb    = 31'(64'd1 << Q30_SHIFT);
                    n_state = T_DONE;
                end else begin
                    n_rem   = UW'(r_sq);
                    n_q     = '0;
                    n_cnt   = '0;
                    n_state = T_DIVB;
                end
            end
            T_DIVB: begin
                // z = floor(mag^2 * 2^60 / d)
                opa   = r_rem << 1;
                opb   = UW'(r_d);
                n_rem = ge ? diff[UW-1:0] : (r_rem << 1);
                n_q   = {r_q[UW-2:0], ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(DIVB_STEPS - 1)) begin
                    n_rem   = {r_q[UW-2:0], ge};
                    n_q     = '0;
                    n_one   = UW'(1) << SQRT_TOP;
                    n_cnt   = '0;
                    n_state = T_SQRT;
                end
            end
            T_SQRT: begin
                // digit-by-digit integer square root of z
                opa   = r_rem;
                opb   = r_q + r_one;
                n_one = r_one >> 2;
                n_cnt = r_cnt + 7'd1;
                if (ge) begin
                    n_rem = diff[UW-1:0];
                    n_q   = (r_q >> 1) + r_one;
                end else begin
                    n_q   = r_q >> 1;
                end
                if (r_cnt == 7'(SQRT_STEPS - 1)) begin
                    n_tb    = ge ? 31'((r_q >> 1) + r_one) : 31'(r_q >> 1);
                    n_state = T_DONE;
                end
            end
            T_DONE: begin
                o_done  = 1'b1;
                n_state = T_IDLE;
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    assign o_tau_a = i_neg ? (TAU_W'(0) - TAU_W'(r_ta)) : TAU_W'(r_ta);
    assign o_tau_b = i_neg ? (TAU_W'(0) - TAU_W'(r_tb)) : TAU_W'(r_tb);

endmodule

FILE: rtl/kendall_tau_b_counter_top.sv
// ----------------------------------------------------------------------------
// kendall_tau_b_counter_top
// kendall tau-b counter built on an iterative merge-sort engine
// ----------------------------------------------------------------------------
// usage
//   input channel: one (x_key, y_key) word per handshake (i_valid / o_ready);
//   the word with last_item set closes the data set and starts the run.
//   output channel: one result word per data set (o_valid / i_ready) with
//   pair counts, tie counts, score, tau-a, tau-b and the two flags.
//   loading takes a word on each handshake. after the last word the block is
//   busy: two merge sorts of ceil(log2 n) passes each on the ping-pong memory
//   ports, plus two tie scans over the sorted data, and the shared tau unit
//   (31 division steps, 60 scaled division steps, 30 square root steps).
//   words past MAX_ITEMS are dropped and reported with overflow_flag.
//   the result sits in an output register; loading of the next set goes on
//   while it waits, and the block holds at the end of the next run until
//   the receiver takes the pending result.
//   reset clears the control state only; the key memories need no clearing.
// ----------------------------------------------------------------------------
module kendall_tau_b_counter_top #(
    parameter int MAX_ITEMS = ktb_pkg::MAX_ITEMS_DEF,
    parameter int KEY_WIDTH = ktb_pkg::KEY_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ktb_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ktb_pkg::t_out_word o_data
);
    import ktb_pkg::*;

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int CWX = CW + 2;
    localparam int PW  = 2 * CW;
    localparam int SW  = PW + 2;
    localparam int DW  = 2 * KEY_WIDTH;

    // ping-pong key memories, word = {x, y} in order-preserving form
    logic [DW-1:0] mem_a [MAX_ITEMS];
    logic [DW-1:0] mem_b [MAX_ITEMS];
    logic [DW-1:0] ra0, ra1, rb0, rb1;
    logic          we_a, we_b;
    logic [AW-1:0] wa_a, wa_b, raddr0, raddr1;
    logic [DW-1:0] wd_a, wd_b;

    t_state r_state, n_state;
    logic   r_sel, n_sel;       // which memory holds the current data
    logic   r_phase, n_phase;   // 0: sort by (x,y), 1: sort by y
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_drop, n_drop;
    logic [CW-1:0]  r_n, n_n;
    logic           r_ovf, n_ovf;
    logic [CWX-1:0] r_w, n_w, r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [CWX-1:0] r_i, n_i, r_j, n_j, r_o, n_o;
    logic [CWX-1:0] r_si, n_si;
    logic           r_sv, n_sv, r_hp, n_hp;
    logic [DW-1:0]  r_prev, n_prev;
    logic [CW-1:0]  r_ra, n_ra, r_rb, n_rb;
    logic [PW-1:0]  r_m1, n_m1, r_m2, n_m2, r_n3, n_n3, r_dis, n_dis;
    logic [PW-1:0]  r_npair, n_npair, r_mag, n_mag;
    logic [SW-1:0]  r_con, n_con, r_s, n_s;
    logic           r_neg, n_neg, r_undef, n_undef;
    logic [TAU_W-1:0] r_ta, n_ta, r_tb, n_tb;
    logic           r_ovalid, n_ovalid;
    t_out_word      r_out, n_out;

    logic           load_we, merge_we;
    logic [DW-1:0]  load_word, merge_word;
    logic [DW-1:0]  d0, d1;
    logic           tau_start, tau_done;
    logic [TAU_W-1:0] tau_a, tau_b;
    logic [KEY_WIDTH-1:0] xk, yk;
    logic [CWX-1:0] mid_c, hi_c, lo_nx;
    logic           li, rj, tr;
    logic           xeq, yeq;
    logic [SW-1:0]  con_c, s_c;

    // keys: sign-fit to KEY_WIDTH, flip the sign bit for unsigned ordering
    assign xk = KEY_WIDTH'(i_data.x_key) ^ (KEY_WIDTH'(1) << (KEY_WIDTH - 1));
    assign yk = KEY_WIDTH'(i_data.y_key) ^ (KEY_WIDTH'(1) << (KEY_WIDTH - 1));
    assign load_word = {xk, yk};

    assign o_ready = (r_state == ST_LOAD);
    assign load_we = i_valid && o_ready && (r_cnt < CW'(MAX_ITEMS));

    // memory write steering: loads go to a, merges to the idle memory
    assign we_a = load_we | (merge_we & r_sel);
    assign wd_a = load_we ? load_word : merge_word;
    assign wa_a = load_we ? r_cnt[AW-1:0] : r_o[AW-1:0];
    assign we_b = merge_we & ~r_sel;
    assign wd_b = merge_word;
    assign wa_b = r_o[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_a] <= wd_a;
        end
        ra0 <= mem_a[raddr0];
        ra1 <= mem_a[raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[wa_b] <= wd_b;
        end
        rb0 <= mem_b[raddr0];
        rb1 <= mem_b[raddr1];
    end

    assign d0 = r_sel ? rb0 : ra0;
    assign d1 = r_sel ? rb1 : ra1;

    // shared tau unit
    ktb_tau #(
        .PW (PW)
    ) u_tau (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tau_start),
        .i_npair (r_npair),
        .i_m1    (r_m1),
        .i_m2    (r_m2),
        .i_mag   (r_mag),
        .i_neg   (r_neg),
        .o_done  (tau_done),
        .o_tau_a (tau_a),
        .o_tau_b (tau_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_sel    <= 1'b0;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
        end
        r_phase <= n_phase;
        r_n     <= n_n;
        r_ovf   <= n_ovf;
        r_w     <= n_w;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_o     <= n_o;
        r_si    <= n_si;
        r_sv    <= n_sv;
        r_hp    <= n_hp;
        r_prev  <= n_prev;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_m1    <= n_m1;
        r_m2    <= n_m2;
        r_n3    <= n_n3;
        r_dis   <= n_dis;
        r_npair <= n_npair;
        r_mag   <= n_mag;
        r_con   <= n_con;
        r_s     <= n_s;
        r_neg   <= n_neg;
        r_undef <= n_undef;
        r_ta    <= n_ta;
        r_tb    <= n_tb;
        r_out   <= n_out;
    end

    // run bounds, merge choice, tie compares, concordant count and score
    always_comb begin
        mid_c = ((r_lo + r_w) < CWX'(r_n)) ? (r_lo + r_w) : CWX'(r_n);
        hi_c  = ((r_lo + (r_w << 1)) < CWX'(r_n)) ? (r_lo + (r_w << 1)) : CWX'(r_n);
        lo_nx = r_lo + (r_w << 1);
        li    = r_i < r_mid;
        rj    = r_j < r_hi;
        if (li && rj) begin
            tr = r_phase ? (d1[KEY_WIDTH-1:0] < d0[KEY_WIDTH-1:0]) : (d1 < d0);
        end else begin
            tr = rj;
        end
        xeq   = d0[DW-1:KEY_WIDTH] == r_prev[DW-1:KEY_WIDTH];
        yeq   = d0[KEY_WIDTH-1:0] == r_prev[KEY_WIDTH-1:0];
        con_c = SW'(r_npair) + SW'(r_n3) - SW'(r_m1) - SW'(r_m2) - SW'(r_dis);
        s_c   = con_c - SW'(r_dis);
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_n       = r_n;
        n_ovf     = r_ovf;
        n_w       = r_w;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_i       = r_i;
        n_j       = r_j;
        n_o       = r_o;
        n_si      = r_si;
        n_sv      = r_sv;
        n_hp      = r_hp;
        n_prev    = r_prev;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_m1      = r_m1;
        n_m2      = r_m2;
        n_n3      = r_n3;
        n_dis     = r_dis;
        n_npair   = r_npair;
        n_mag     = r_mag;
        n_con     = r_con;
        n_s       = r_s;
        n_neg     = r_neg;
        n_undef   = r_undef;
        n_ta      = r_ta;
        n_tb      = r_tb;
        n_out     = r_out;
        n_ovalid  = r_ovalid & ~i_ready;
        merge_we   = 1'b0;
        merge_word = tr ? d1 : d0;
        raddr0    = '0;
        raddr1    = '0;
        tau_start = 1'b0;

        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_data.last_item) begin
                        // close the set and start the (x, y) sort
                        n_n     = (r_cnt < CW'(MAX_ITEMS)) ? r_cnt + CW'(1) : r_cnt;
                        n_ovf   = r_drop | (r_cnt >= CW'(MAX_ITEMS));
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_sel   = 1'b0;
                        n_phase = 1'b0;
                        n_w     = CWX'(1);
                        n_dis   = '0;
                        n_state = ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                if (r_w < CWX'(r_n)) begin
                    n_lo    = '0;
                    n_state = ST_RUN;
                end else begin
                    // sort done: tie scan over the ordered data
                    n_si    = '0;
                    n_sv    = 1'b0;
                    n_hp    = 1'b0;
                    n_ra    = '0;
                    n_rb    = '0;
                    if (!r_phase) begin
                        n_m1 = '0;
                        n_n3 = '0;
                    end else begin
                        n_m2 = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_RUN: begin
                n_mid   = mid_c;
                n_hi    = hi_c;
                n_i     = r_lo;
                n_j     = mid_c;
                n_o     = r_lo;
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                raddr0  = r_i[AW-1:0];
                raddr1  = r_j[AW-1:0];
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (li || rj) begin
                    merge_we = 1'b1;
                    n_o      = r_o + CWX'(1);
                    if (tr) begin
                        n_j = r_j + CWX'(1);
                        if (li && r_phase) begin
                            // every left element still waiting is an inversion
                            n_dis = r_dis + PW'(r_mid - r_i);
                        end
                    end else begin
                        n_i = r_i + CWX'(1);
                    end
                    n_state = ST_FETCH;
                end else if (lo_nx >= CWX'(r_n)) begin
                    n_sel   = ~r_sel;
                    n_w     = r_w << 1;
                    n_state = ST_PASS;
                end else begin
                    n_lo    = lo_nx;
                    n_state = ST_RUN;
                end
            end
            ST_SCAN: begin
                raddr0 = r_si[AW-1:0];
                if (r_si < CWX'(r_n)) begin
                    n_si = r_si + CWX'(1);
                    n_sv = 1'b1;
                end else begin
                    n_sv = 1'b0;
                end
                if (r_sv) begin
                    n_prev = d0;
                    n_hp   = 1'b1;
                    if (r_hp) begin
                        if (!r_phase) begin
                            if (xeq) begin
                                n_ra = r_ra + CW'(1);
                                n_m1 = r_m1 + PW'(r_ra) + PW'(1);
                            end else begin
                                n_ra = '0;
                            end
                            if (xeq && yeq) begin
                                n_rb = r_rb + CW'(1);
                                n_n3 = r_n3 + PW'(r_rb) + PW'(1);
                            end else begin
                                n_rb = '0;
                            end
                        end else begin
                            if (yeq) begin
                                n_ra = r_ra + CW'(1);
                                n_m2 = r_m2 + PW'(r_ra) + PW'(1);
                            end else begin
                                n_ra = '0;
                            end
                        end
                    end
                end
                if ((r_si >= CWX'(r_n)) && !r_sv) begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_w     = CWX'(1);
                        n_state = ST_PASS;
                    end else begin
                        n_state = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                n_npair = (r_n == '0) ? '0 : PW'((PW'(r_n) * PW'(r_n - CW'(1))) >> 1);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_con   = con_c;
                n_s     = s_c;
                n_neg   = s_c[SW-1];
                n_mag   = s_c[SW-1] ? PW'(SW'(0) - s_c) : PW'(s_c);
                n_undef = (r_npair == '0) || (r_npair == r_m1) || (r_npair == r_m2);
                n_ta    = '0;
                n_tb    = '0;
                n_state = ST_OUT;
                if (!((r_npair == '0) || (r_npair == r_m1) || (r_npair == r_m2))) begin
                    n_state = ST_TAU;
                end
            end
            ST_TAU: begin
                tau_start = 1'b1;
                if (tau_done) begin
                    n_ta    = tau_a;
                    n_tb    = tau_b;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_ovalid) begin
                    n_out.pair_total       = CNT_W'(r_npair);
                    n_out.ties_first       = CNT_W'(r_m1);
                    n_out.ties_second      = CNT_W'(r_m2);
                    n_out.ties_joint       = CNT_W'(r_n3);
                    n_out.discordant_count = CNT_W'(r_dis);
                    n_out.concordant_count = CNT_W'(r_con);
                    n_out.score            = SCORE_W'(r_s);
                    n_out.tau_a            = r_ta;
                    n_out.tau_b            = r_tb;
                    n_out.undefined_flag   = r_undef;
                    n_out.overflow_flag    = r_ovf;
                    n_ovalid = 1'b1;
                    n_sel    = 1'b0;
                    n_state  = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

FILE: rtl/ktb_checker.sv
// ----------------------------------------------------------------------------
// ktb_checker
// port-level checks of the kendall tau-b counter, bound to the top level
// ----------------------------------------------------------------------------
module ktb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input ktb_pkg::t_in_word  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input ktb_pkg::t_out_word o_data
);
    import ktb_pkg::*;

    // a pending result word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped before accept");

    // a stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result word changed while stalled");

    // closing word starts a busy run
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.last_item |=> !o_ready)
        else $error("accepting words right after the last word");

    // undefined taus are zero
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.undefined_flag |-> (o_data.tau_a == 0 && o_data.tau_b == 0))
        else $error("undefined result with nonzero tau");

    // tau-b magnitude never exceeds one
    a_taub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.tau_b <= 32'sd1073741824 && o_data.tau_b >= -32'sd1073741824))
        else $error("tau-b out of range");

endmodule

bind kendall_tau_b_counter_top ktb_checker u_ktb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
